### design/pgv_pkg.sv
// Shared types and constants for the particle gravity velocity update core.
package pgv_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd4;

    localparam logic [15:0] GRAVITY_X_RST     = 16'h0000;
    localparam logic [15:0] GRAVITY_Y_RST     = 16'h0000;
    localparam logic [15:0] GRAVITY_Z_RST     = 16'hF600;
    localparam logic [15:0] GRAVITY_SCALE_RST = 16'd4096;
    localparam logic [15:0] TIME_STEP_RST     = 16'd1092;

    localparam longint DIR_ONE   = 64'sd16384;
    localparam longint VEL_LIMIT = 64'sd1073741824;

    localparam int VEL_SHIFT  = 8;
    localparam int GRAV_SHIFT = 22;
    localparam int SPD_SHIFT  = 6;
    localparam int DIR_FRAC   = 14;

    localparam int MAG_W  = 31;
    localparam int SQ_W   = 62;
    localparam int LEN_W  = 32;
    localparam int QUOT_W = 15;

    typedef struct packed {
        logic signed [15:0] gravity_x;
        logic signed [15:0] gravity_y;
        logic signed [15:0] gravity_z;
        logic [15:0]        gravity_scale;
        logic [15:0]        time_step;
    } cfg_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  last;
    } side_t;

endpackage

### design/pgv_in_if.sv
// Input channel: particle direction, speed and last flag.
interface pgv_in_if #(parameter int W = 16);
    logic               valid;
    logic               ready;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    logic [W-1:0]        speed_in;
    logic                last_in;

    modport source (output valid, dir_x, dir_y, dir_z, speed_in, last_in, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, speed_in, last_in, output ready);
endinterface

### design/pgv_out_if.sv
// Output channel: new direction, new speed and last flag.
interface pgv_out_if #(parameter int W = 16);
    logic               valid;
    logic               ready;
    logic signed [W-1:0] new_dir_x;
    logic signed [W-1:0] new_dir_y;
    logic signed [W-1:0] new_dir_z;
    logic [W-1:0]        new_speed;
    logic                last_out;

    modport source (output valid, new_dir_x, new_dir_y, new_dir_z, new_speed, last_out,
                    input ready);
    modport sink   (input valid, new_dir_x, new_dir_y, new_dir_z, new_speed, last_out,
                    output ready);
endinterface

### design/pgv_cfg_regs.sv
// Configuration register file: gravity vector, gravity scale and time step.
module pgv_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [pgv_pkg::CFG_IDX_W-1:0]       index,
    input  logic [pgv_pkg::CFG_DATA_W-1:0]      data,
    output pgv_pkg::cfg_t                       cfg
);
    import pgv_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_x     <= GRAVITY_X_RST;
            cfg_reg.gravity_y     <= GRAVITY_Y_RST;
            cfg_reg.gravity_z     <= GRAVITY_Z_RST;
            cfg_reg.gravity_scale <= GRAVITY_SCALE_RST;
            cfg_reg.time_step     <= TIME_STEP_RST;
        end
        else if (we)
        begin
            unique case (index)
                CFG_GRAVITY_X:     cfg_reg.gravity_x     <= data;
                CFG_GRAVITY_Y:     cfg_reg.gravity_y     <= data;
                CFG_GRAVITY_Z:     cfg_reg.gravity_z     <= data;
                CFG_GRAVITY_SCALE: cfg_reg.gravity_scale <= data;
                CFG_TIME_STEP:     cfg_reg.time_step     <= data;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/pgv_vec.sv
// Velocity vector pipeline: products, gravity term, clamp, squares and sum of squares.
module pgv_vec #(parameter int W = 16) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [W-1:0]          dir_x,
    input  logic signed [W-1:0]          dir_y,
    input  logic signed [W-1:0]          dir_z,
    input  logic [W-1:0]                 speed,
    input  logic                         last,
    input  pgv_pkg::cfg_t                cfg,
    output logic                         out_valid,
    output logic [63:0]                  sumsq,
    output pgv_pkg::side_t               side
);
    import pgv_pkg::*;

    localparam int PW = 2 * W + 1;
    localparam int AW = PW - VEL_SHIFT;
    localparam int GW = 49;
    localparam int BW = GW - GRAV_SHIFT;

    logic [4:0]                 vld_reg;
    logic [3:0]                 last_reg;

    // stage 1
    logic signed [PW-1:0]       prod_next [3];
    logic signed [PW-1:0]       prod_reg  [3];
    logic [31:0]                gsc_next;
    logic [31:0]                gsc_reg;
    // stage 2
    logic signed [GW-1:0]       gp        [3];
    logic signed [AW-1:0]       a_next    [3];
    logic signed [AW-1:0]       a_reg     [3];
    logic signed [BW-1:0]       b_next    [3];
    logic signed [BW-1:0]       b_reg     [3];
    // stage 3
    logic [2:0][MAG_W-1:0]      mag_next;
    logic [2:0][MAG_W-1:0]      mag_reg;
    logic [2:0]                 neg_next;
    logic [2:0]                 neg_reg;
    // stage 4
    logic [SQ_W-1:0]            sq_next   [3];
    logic [SQ_W-1:0]            sq_reg    [3];
    logic [2:0][MAG_W-1:0]      mag4_reg;
    logic [2:0]                 neg4_reg;
    // stage 5
    logic [SQ_W-1:0]            sum_next;
    logic [SQ_W-1:0]            sum_reg;
    side_t                      side_reg;

    logic signed [W-1:0]        dir [3];
    logic signed [15:0]         grav [3];

    assign dir[0]  = dir_x;
    assign dir[1]  = dir_y;
    assign dir[2]  = dir_z;
    assign grav[0] = cfg.gravity_x;
    assign grav[1] = cfg.gravity_y;
    assign grav[2] = cfg.gravity_z;

    always_comb
    begin
        logic signed [63:0] s;
        logic signed [63:0] c;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PW'(dir[i]) * PW'($signed({1'b0, speed}));
            gp[i]        = GW'(grav[i]) * GW'($signed({1'b0, gsc_reg}));
            a_next[i]    = AW'(prod_reg[i] >>> VEL_SHIFT);
            b_next[i]    = BW'(gp[i] >>> GRAV_SHIFT);
            s = 64'(a_reg[i]) + 64'(b_reg[i]);
            if (s < -VEL_LIMIT)
                c = -VEL_LIMIT;
            else if (s > VEL_LIMIT)
                c = VEL_LIMIT;
            else
                c = s;
            neg_next[i] = c[63];
            mag_next[i] = MAG_W'(c[63] ? -c : c);
            sq_next[i]  = SQ_W'(mag_reg[i]) * SQ_W'(mag_reg[i]);
        end
        gsc_next = 32'(cfg.gravity_scale) * 32'(cfg.time_step);
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            gsc_reg   <= gsc_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            sq_reg    <= sq_next;
            mag4_reg  <= mag_reg;
            neg4_reg  <= neg_reg;
            sum_reg   <= sum_next;
            last_reg  <= {last_reg[2:0], last};
            side_reg.mag  <= mag4_reg;
            side_reg.neg  <= neg4_reg;
            side_reg.last <= last_reg[3];
        end
    end

    assign out_valid = vld_reg[4];
    assign sumsq     = 64'(sum_reg);
    assign side      = side_reg;

endmodule

### design/pgv_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module pgv_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [63:0]                   n,
    input  pgv_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [pgv_pkg::LEN_W-1:0]     len,
    output pgv_pkg::side_t                side_out
);
    import pgv_pkg::*;

    localparam int STEPS = 32;

    logic [STEPS-1:0] vld_reg;
    logic [63:0]      n_reg    [STEPS];
    logic [63:0]      r_reg    [STEPS];
    side_t            side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_in;
        logic [63:0] r_in;
        side_t       s_in;
        logic [63:0] t;
        logic        ge;
        logic [63:0] n_next;
        logic [63:0] r_next;

        if (k == 0)
        begin : g_first
            assign n_in = n;
            assign r_in = '0;
            assign s_in = side_in;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign t      = r_in + BIT;
        assign ge     = n_in >= t;
        assign n_next = ge ? n_in - t : n_in;
        assign r_next = ge ? (r_in >> 1) + BIT : r_in >> 1;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= s_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
    end

    assign out_valid = vld_reg[STEPS-1];
    assign len       = LEN_W'(r_reg[STEPS-1]);
    assign side_out  = side_reg[STEPS-1];

endmodule

### design/pgv_div.sv
// Pipelined normalizing divider, one quotient bit per stage, plus output formatting.
module pgv_div #(parameter int W = 16) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pgv_pkg::LEN_W-1:0]     len,
    input  pgv_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic signed [W-1:0]           new_dir_x,
    output logic signed [W-1:0]           new_dir_y,
    output logic signed [W-1:0]           new_dir_z,
    output logic [W-1:0]                  new_speed,
    output logic                          last_out
);
    import pgv_pkg::*;

    localparam int     STEPS = QUOT_W;
    localparam int     RW    = MAG_W + DIR_FRAC + 1;
    localparam longint DMAX  = (longint'(1) <<< (W - 1)) - 1;
    localparam longint DMIN  = -DMAX - 1;
    localparam longint ONE_C = (DIR_ONE > DMAX) ? DMAX : DIR_ONE;
    localparam logic [63:0] FMASK = (64'd1 << W) - 64'd1;

    logic [STEPS:0]              vld_reg;
    logic [2:0][RW-1:0]          rem_reg  [STEPS];
    logic [2:0][QUOT_W-1:0]      q_reg    [STEPS];
    logic [LEN_W-1:0]            len_reg  [STEPS];
    side_t                       side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int SH = STEPS - 1 - k;
        logic [2:0][RW-1:0]     rem_in;
        logic [2:0][QUOT_W-1:0] q_in;
        logic [LEN_W-1:0]       len_in;
        side_t                  s_in;
        logic [RW-1:0]          d;
        logic [2:0][RW-1:0]     rem_next;
        logic [2:0][QUOT_W-1:0] q_next;

        if (k == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = RW'({side_in.mag[i], {DIR_FRAC{1'b0}}});
            end
            assign q_in   = '0;
            assign len_in = len;
            assign s_in   = side_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign len_in = len_reg[k-1];
            assign s_in   = side_reg[k-1];
        end

        assign d = RW'(len_in) << SH;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i]    = (rem_in[i] >= d) ? rem_in[i] - d : rem_in[i];
                q_next[i]      = q_in[i];
                q_next[i][SH]  = rem_in[i] >= d;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                len_reg[k]  <= len_in;
                side_reg[k] <= s_in;
            end
        end
    end

    logic signed [W-1:0] dir_next [3];
    logic [W-1:0]        spd_next;
    logic signed [W-1:0] dir_reg  [3];
    logic [W-1:0]        spd_reg;
    logic                last_reg;

    always_comb
    begin
        logic [LEN_W-1:0] lf;
        longint           qv;
        logic [63:0]      s64;
        lf = len_reg[STEPS-1];
        for (int i = 0; i < 3; i++)
        begin
            qv = longint'(q_reg[STEPS-1][i]);
            if (side_reg[STEPS-1].neg[i])
                qv = -qv;
            if (qv > DMAX)
                qv = DMAX;
            else if (qv < DMIN)
                qv = DMIN;
            dir_next[i] = W'(qv);
        end
        if (lf == '0)
        begin
            dir_next[0] = '0;
            dir_next[1] = '0;
            dir_next[2] = W'(ONE_C);
        end
        s64      = 64'(lf) >> SPD_SHIFT;
        spd_next = (s64 > FMASK) ? W'(FMASK) : W'(s64);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_reg  <= dir_next;
            spd_reg  <= spd_next;
            last_reg <= side_reg[STEPS-1].last;
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign new_dir_x = dir_reg[0];
    assign new_dir_y = dir_reg[1];
    assign new_dir_z = dir_reg[2];
    assign new_speed = spd_reg;
    assign last_out  = last_reg;

endmodule

### design/particle_gravity_velocity_update_core.sv
// Top level of the particle gravity velocity update core.
//
// in_stream carries one particle per transaction: unit direction (signed Q2.14)
// and speed (unsigned Q8.8) plus a last flag. out_stream returns one transaction
// per input: normalized new direction, saturated new speed, and the last flag.
// The configuration port (cfg_we, cfg_index, cfg_data) writes gravity, gravity
// scale and time step; write it only while the pipeline is empty.
//
// There are 5 vector stages, 32 square-root stages (one result bit each), 15
// divider stages (one quotient bit each) and one output register. Throughput is
// one transaction per cycle when not stalled; the square-root and divider
// pipelines set the depth. A zero-length vector yields direction (0, 0, one).
//
// Reset clears all valid bits and loads the register defaults (gravity 0, 0,
// minus ten; scale one; time step 1092). When the receiver holds ready low with
// a result waiting, the whole pipeline freezes and in_stream.ready goes low;
// nothing is dropped or repeated.
module particle_gravity_velocity_update_core #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pgv_in_if.sink                           in_stream,
    pgv_out_if.source                        out_stream,
    input  logic                             cfg_we,
    input  logic [pgv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgv_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pgv_pkg::*;

    cfg_t               cfg;
    logic               en;
    logic               vec_valid;
    logic [63:0]        sumsq;
    side_t              vec_side;
    logic               sq_valid;
    logic [LEN_W-1:0]   len;
    side_t              sq_side;

    assign en              = !out_stream.valid || out_stream.ready;
    assign in_stream.ready = en;

    pgv_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    pgv_vec #(.W(FIELD_WIDTH)) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_stream.valid),
        .dir_x     (in_stream.dir_x),
        .dir_y     (in_stream.dir_y),
        .dir_z     (in_stream.dir_z),
        .speed     (in_stream.speed_in),
        .last      (in_stream.last_in),
        .cfg       (cfg),
        .out_valid (vec_valid),
        .sumsq     (sumsq),
        .side      (vec_side)
    );

    pgv_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vec_valid),
        .n         (sumsq),
        .side_in   (vec_side),
        .out_valid (sq_valid),
        .len       (len),
        .side_out  (sq_side)
    );

    pgv_div #(.W(FIELD_WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .len       (len),
        .side_in   (sq_side),
        .out_valid (out_stream.valid),
        .new_dir_x (out_stream.new_dir_x),
        .new_dir_y (out_stream.new_dir_y),
        .new_dir_z (out_stream.new_dir_z),
        .new_speed (out_stream.new_speed),
        .last_out  (out_stream.last_out)
    );

endmodule
